@@ sv/vcsr_pkg.sv @@
// Package for the vector CSR and vsetvl unit: word types, opcodes, CSR numbers, status codes.
`default_nettype none

package vcsr_pkg;

  localparam int unsigned VectorBitsDefault = 1024;

  localparam logic [63:0] Filler = 64'h1145141919810233;

  // Opcodes
  localparam logic [6:0] OpcSystem  = 7'h73;
  localparam logic [6:0] OpcVector  = 7'h57;
  localparam logic [6:0] OpcLoadFp  = 7'h07;
  localparam logic [6:0] OpcStoreFp = 7'h27;
  localparam logic [6:0] OpcAmo     = 7'h2F;

  localparam logic [2:0] F3OpCfg = 3'd7;

  // Low two bits of funct3 under SYSTEM
  localparam logic [1:0] KindPriv = 2'd0;
  localparam logic [1:0] KindRw   = 2'd1;
  localparam logic [1:0] KindRs   = 2'd2;
  localparam logic [1:0] KindRc   = 2'd3;

  // CSR numbers
  localparam logic [11:0] CsrVstart = 12'h008;
  localparam logic [11:0] CsrVxsat  = 12'h009;
  localparam logic [11:0] CsrVxrm   = 12'h00A;
  localparam logic [11:0] CsrVcsr   = 12'h00F;
  localparam logic [11:0] CsrVl     = 12'hC20;
  localparam logic [11:0] CsrVtype  = 12'hC21;
  localparam logic [11:0] CsrVlenb  = 12'hC22;

  // Status codes
  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StCsr         = 2'd1;
  localparam logic [1:0] StIllegal     = 2'd2;
  localparam logic [1:0] StUnsupported = 2'd3;

  typedef struct packed {
    logic [31:0] instruction;
    logic [63:0] rs1_value;
    logic [63:0] rs2_value;
  } in_word_t;

  typedef struct packed {
    logic [63:0] rd_value;
    logic [1:0]  status;
  } out_word_t;

endpackage

`default_nettype wire

@@ sv/vector_csr_and_vsetvl_unit.sv @@
// Vector CSR and vsetvl unit: input register, single-pass decode and execute, result register.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+----------------------------------
//   in      | in        | in_valid_i/in_ready_o  | instruction, rs1_value, rs2_value
//   out     | out       | out_valid_o/out_ready_i| rd_value, status
//
// One word per cycle while the result is not stalled; a word passes the input and result registers.
// Execution of a word, including CSR and vl/vtype update, happens as it moves to the
// result register, so the next word already sees the new state.
// A stalled result holds the input register; a further word waits in it.
// Reset clears vstart, vxsat, vxrm, vl, vtype and both valid flags.
`default_nettype none

module vector_csr_and_vsetvl_unit #(
  parameter int unsigned VECTOR_BITS = vcsr_pkg::VectorBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire vcsr_pkg::in_word_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output vcsr_pkg::out_word_t       out_data_o
);
  import vcsr_pkg::*;

  localparam int unsigned VlmaxW = $clog2(VECTOR_BITS) + 4;
  localparam logic [63:0] VlenB  = 64'(VECTOR_BITS / 8);
  localparam logic [VlmaxW-1:0] VlenBits = VlmaxW'(VECTOR_BITS);

  // VLMAX = (VLEN << vt[1:0]) >> (3 + sew + (vt[2] ? 4 : 0)), so vt[2] selects fractional LMUL
  function automatic logic [VlmaxW-1:0] vlmax_f(input logic [15:0] vt);
    logic [3:0]        down;
    logic [VlmaxW-1:0] up;
    down = 4'd3 + {1'b0, vt[5:3]} + (vt[2] ? 4'd4 : 4'd0);
    up   = VlenBits << vt[1:0];
    return up >> down;
  endfunction

  // Pipeline registers
  logic      s1_valid_q;
  in_word_t  s1_q;
  logic      out_valid_q;
  out_word_t out_q;
  logic      adv;
  logic      fire;

  // Architectural state
  logic [15:0] vstart_q, vstart_d;
  logic        vxsat_q, vxsat_d;
  logic [1:0]  vxrm_q, vxrm_d;
  logic [16:0] vl_q, vl_d;
  logic [15:0] vtype_q, vtype_d;

  // Decode
  logic [31:0] ins;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rdf;
  logic [4:0]  r1f;
  logic [11:0] csr;
  logic [1:0]  kind;
  logic [63:0] opnd;
  logic [63:0] old;
  logic        rd_ok;
  logic        wr_ok;

  // vset path
  logic              imm_form;
  logic              vt_ok;
  logic [15:0]       vt;
  logic [63:0]       avl;
  logic [VlmaxW-1:0] vmax;
  logic [VlmaxW+1:0] avl_inc;
  logic [63:0]       nvl;
  logic [16:0]       nvl_trunc;

  // Results of one pass
  logic [63:0] rd_val;
  logic [1:0]  st;
  logic        wr_en;
  logic [63:0] wr_val;
  logic        vset_en;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;
  assign fire       = s1_valid_q && adv;

  assign ins  = s1_q.instruction;
  assign opc  = ins[6:0];
  assign rdf  = ins[11:7];
  assign f3   = ins[14:12];
  assign r1f  = ins[19:15];
  assign csr  = ins[31:20];
  assign kind = f3[1:0];
  assign opnd = f3[2] ? {59'd0, r1f} : s1_q.rs1_value;

  always_comb begin
    rd_ok = 1'b1;
    case (csr)
      CsrVstart: old = {48'd0, vstart_q};
      CsrVxsat:  old = {63'd0, vxsat_q};
      CsrVxrm:   old = {62'd0, vxrm_q};
      CsrVcsr:   old = {61'd0, vxrm_q, vxsat_q};
      CsrVl:     old = {47'd0, vl_q};
      CsrVtype:  old = {48'd0, vtype_q};
      CsrVlenb:  old = VlenB;
      default: begin
        old   = 64'd0;
        rd_ok = 1'b0;
      end
    endcase
  end

  assign wr_ok = (csr == CsrVstart) || (csr == CsrVxsat) || (csr == CsrVxrm) ||
                 (csr == CsrVcsr);

  // vtype source: vsetvli, vsetivli or vsetvl
  assign imm_form = (ins[31:30] == 2'b11);
  always_comb begin
    vt_ok = 1'b1;
    if (!ins[31]) begin
      vt = {5'd0, ins[30:20]};
    end else if (imm_form) begin
      vt = {6'd0, ins[29:20]};
    end else if (ins[31:25] == 7'h40) begin
      vt = s1_q.rs2_value[15:0];
    end else begin
      vt    = 16'd0;
      vt_ok = 1'b0;
    end
  end

  always_comb begin
    if (imm_form) begin
      avl = {59'd0, r1f};
    end else if (rdf == 5'd0 && r1f == 5'd0) begin
      avl = {47'd0, vl_q};
    end else if (r1f == 5'd0) begin
      avl = '1;
    end else begin
      avl = s1_q.rs1_value;
    end
  end

  assign vmax    = vlmax_f(vt);
  assign avl_inc = {1'b0, avl[VlmaxW:0]} + (VlmaxW+2)'(1);

  always_comb begin
    if (avl <= 64'(vmax)) begin
      nvl = avl;
    end else if (avl < 64'({vmax, 1'b0})) begin
      nvl = 64'(avl_inc[VlmaxW+1:1]);
    end else begin
      nvl = 64'(vmax);
    end
  end

  assign nvl_trunc = nvl[16:0];

  always_comb begin
    rd_val  = Filler;
    st      = StOk;
    wr_en   = 1'b0;
    wr_val  = 64'd0;
    vset_en = 1'b0;
    if (opc == OpcSystem) begin
      if (kind == KindPriv) begin
        st = StIllegal;
      end else if (kind == KindRw) begin
        if ((rdf != 5'd0 && !rd_ok) || !wr_ok) begin
          st = StCsr;
        end else begin
          wr_en  = 1'b1;
          wr_val = opnd;
          if (rdf != 5'd0) begin
            rd_val = old;
          end
        end
      end else begin
        if (!rd_ok || (r1f != 5'd0 && !wr_ok)) begin
          st = StCsr;
        end else begin
          rd_val = old;
          wr_en  = (r1f != 5'd0);
          wr_val = (kind == KindRs) ? (old | opnd) : (old & ~opnd);
        end
      end
    end else if (opc == OpcVector && f3 == F3OpCfg) begin
      if (!vt_ok) begin
        st = StIllegal;
      end else begin
        vset_en = 1'b1;
        rd_val  = {47'd0, nvl_trunc};
      end
    end else if (opc == OpcVector || opc == OpcLoadFp || opc == OpcStoreFp ||
                 opc == OpcAmo) begin
      st = StUnsupported;
    end else begin
      st = StIllegal;
    end
  end

  always_comb begin
    vstart_d = vstart_q;
    vxsat_d  = vxsat_q;
    vxrm_d   = vxrm_q;
    vl_d     = vl_q;
    vtype_d  = vtype_q;
    if (fire && wr_en) begin
      case (csr)
        CsrVstart: vstart_d = wr_val[15:0];
        CsrVxsat:  vxsat_d  = wr_val[0];
        CsrVxrm:   vxrm_d   = wr_val[1:0];
        CsrVcsr: begin
          vxsat_d = wr_val[0];
          vxrm_d  = wr_val[2:1];
        end
        default: ;
      endcase
    end
    if (fire && vset_en) begin
      vtype_d  = vt;
      vl_d     = nvl_trunc;
      vstart_d = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vstart_q    <= 16'd0;
      vxsat_q     <= 1'b0;
      vxrm_q      <= 2'd0;
      vl_q        <= 17'd0;
      vtype_q     <= 16'd0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      vstart_q <= vstart_d;
      vxsat_q  <= vxsat_d;
      vxrm_q   <= vxrm_d;
      vl_q     <= vl_d;
      vtype_q  <= vtype_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_data_i;
    end
    if (fire) begin
      out_q.rd_value <= rd_val;
      out_q.status   <= st;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_vl_within_vlmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {47'd0, vl_q} <= 64'(vlmax_f(vtype_q)))
    else $error("vl exceeds VLMAX of current vtype");

  a_error_gives_filler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StOk |-> out_data_o.rd_value == Filler)
    else $error("error status without filler value");

  a_vset_clears_vstart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && vset_en |=> vstart_q == 16'd0 && out_data_o.rd_value == {47'd0, vl_q})
    else $error("vset did not clear vstart or report new vl");

  a_state_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(vl_q) && $stable(vtype_q) && $stable(vstart_q) &&
              $stable(vxsat_q) && $stable(vxrm_q))
    else $error("CSR state changed with no word executing");
`endif

endmodule

`default_nettype wire
